// ===== hdl/bicubic_image_resampler_unit_defines.svh =====
`ifndef BICUBIC_IMAGE_RESAMPLER_UNIT_DEFINES_SVH
`define BICUBIC_IMAGE_RESAMPLER_UNIT_DEFINES_SVH

// checks that hold outside reset, clocked on clk
`define BIR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bir check failed");

// checks that must also hold across reset
`define BIR_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bir reset check failed");

`endif

// ===== hdl/bir_pkg.sv =====
package bir_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int SIZE_REG_W = 9;
  localparam int STEP_W     = 25;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_H     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_V     = 3'd3;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

endpackage

// ===== hdl/bicubic_image_resampler_unit.sv =====
// channel   dir  handshake                   payload
// command   in   start / busy                action, load_*, in_*, dest_*
// result    out  out_valid strobe, no stall  out_red/green/blue, out_col/row
// config    in   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// a load beat leaves busy low, so loads can follow every cycle while no sample holds busy high
// a sample beat keeps busy high through the position multiply, the edge clamp
// and all but the last of the sixteen frame-store reads
// after the last read the result passes through 7+7 cubic stages and the output register
// synchronous reset clears control; the frame store holds no reset value
// the result strobe cannot be held off, so nothing inside ever stalls
`include "bicubic_image_resampler_unit_defines.svh"

module bicubic_image_resampler_unit import bir_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action,
  input  logic [7:0]            load_col,
  input  logic [7:0]            load_row,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [11:0]           dest_col,
  input  logic [11:0]           dest_row,
  output logic                  out_valid,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [11:0]           out_col,
  output logic [11:0]           out_row,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RH     = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = 1 << (CW + RH);
  localparam int SZ_W   = 13;
  localparam int PROD_W = 12 + STEP_W;
  localparam int POS_W  = PROD_W + 1;
  localparam int IP_W   = POS_W - FRAC_W;
  localparam int PIX_W  = 8 + FRAC_W + 1;
  localparam int LINE_W = PIX_W + 6;
  localparam int OUT_W  = LINE_W + 6;
  localparam int RTAG_W = FRAC_W + 12 + 12 + 2;
  localparam int CTAG_W = 24;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAP   = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  localparam logic signed [OUT_W-1:0] VMAX = OUT_W'(255 << FRAC_W);
  localparam logic [FRAC_W:0] HALF = (FRAC_W+1)'(1 << (FRAC_W - 1));

  // configuration
  logic [SIZE_REG_W-1:0] src_width, src_height;
  logic [STEP_W-1:0]     step_h, step_v;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SIZE_REG_W'(256);
      src_height <= SIZE_REG_W'(256);
      step_h     <= STEP_W'(65536);
      step_v     <= STEP_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[SIZE_REG_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SIZE_REG_W-1:0];
        REG_STEP_H:     step_h     <= cfg_data[STEP_W-1:0];
        REG_STEP_V:     step_v     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // effective image size, zero acts as one and sizes above the maximum are capped
  logic [SZ_W-1:0] w_eff, h_eff, w_last, h_last;
  always_comb begin
    if (src_width == '0) w_eff = SZ_W'(1);
    else if (SZ_W'(src_width) > SZ_W'(MAX_WIDTH)) w_eff = SZ_W'(MAX_WIDTH);
    else w_eff = SZ_W'(src_width);
    if (src_height == '0) h_eff = SZ_W'(1);
    else if (SZ_W'(src_height) > SZ_W'(MAX_HEIGHT)) h_eff = SZ_W'(MAX_HEIGHT);
    else h_eff = SZ_W'(src_height);
    w_last = w_eff - SZ_W'(1);
    h_last = h_eff - SZ_W'(1);
  end

  function automatic logic [SZ_W-1:0] clamp_coord(input logic signed [IP_W:0] cc,
                                                  input logic [SZ_W-1:0] lim);
    logic [SZ_W-1:0] r;
    if (cc < 0) r = '0;
    else if (cc > $signed({{(IP_W-SZ_W+1){1'b0}}, lim})) r = lim;
    else r = cc[SZ_W-1:0];
    return r;
  endfunction

  // sequencer
  logic [1:0]  state;
  logic [3:0]  cnt;
  logic        accept;
  logic [11:0] dcol, drow;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic signed [POS_W-1:0] pos_x, pos_y;
  logic [FRAC_W-1:0] xf, yf;
  logic [CW-1:0] cols [4];
  logic [RH-1:0] rows [4];

  assign busy   = (state != ST_IDLE) && !(state == ST_READ && cnt == 4'hF);
  assign accept = start && !busy;

  assign pos_x = $signed({1'b0, prod_x}) - $signed({{(POS_W-FRAC_W-1){1'b0}}, HALF});
  assign pos_y = $signed({1'b0, prod_y}) - $signed({{(POS_W-FRAC_W-1){1'b0}}, HALF});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && action == ACT_SAMPLE) state <= ST_MAP;
        end
        ST_MAP:   state <= ST_CLAMP;
        ST_CLAMP: begin
          state <= ST_READ;
          cnt   <= '0;
        end
        ST_READ: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'hF) begin
            state <= (accept && action == ACT_SAMPLE) ? ST_MAP : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action == ACT_SAMPLE) begin
      dcol <= dest_col;
      drow <= dest_row;
    end
    if (state == ST_MAP) begin
      prod_x <= PROD_W'(dcol) * PROD_W'(step_h);
      prod_y <= PROD_W'(drow) * PROD_W'(step_v);
    end
    if (state == ST_CLAMP) begin
      xf <= pos_x[FRAC_W-1:0];
      yf <= pos_y[FRAC_W-1:0];
      for (int k = 0; k < 4; k++) begin
        cols[k] <= CW'(clamp_coord($signed({pos_x[POS_W-1], pos_x[POS_W-1:FRAC_W]})
                                   + (IP_W+1)'(k) - (IP_W+1)'(1), w_last));
        rows[k] <= RH'(clamp_coord($signed({pos_y[POS_W-1], pos_y[POS_W-1:FRAC_W]})
                                   + (IP_W+1)'(k) - (IP_W+1)'(1), h_last));
      end
    end
  end

  // frame store
  logic [SZ_W-1:0] lc_ext, lr_ext;
  logic            ram_we;
  logic [23:0]     rdata;

  assign lc_ext = SZ_W'(load_col);
  assign lr_ext = SZ_W'(load_row);
  assign ram_we = accept && action == ACT_LOAD &&
                  lc_ext < SZ_W'(MAX_WIDTH) && lr_ext < SZ_W'(MAX_HEIGHT);

  bir_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({lr_ext[RH-1:0], lc_ext[CW-1:0]}),
    .wdata ({in_red, in_green, in_blue}),
    .raddr ({rows[cnt[3:2]], cols[cnt[1:0]]}),
    .rdata (rdata)
  );

  // read beat side band, lines up with rdata
  logic        rd1_v, rd1_last;
  logic [1:0]  rd1_row;
  logic [FRAC_W-1:0] rd1_xf, rd1_yf;
  logic [11:0] rd1_dcol, rd1_drow;

  always_ff @(posedge clk) begin
    if (rst) rd1_v <= 1'b0;
    else     rd1_v <= (state == ST_READ);
  end

  always_ff @(posedge clk) begin
    rd1_last <= (cnt[1:0] == 2'd3);
    rd1_row  <= cnt[3:2];
    rd1_xf   <= xf;
    rd1_yf   <= yf;
    rd1_dcol <= dcol;
    rd1_drow <= drow;
  end

  logic [23:0] pxa, pxb, pxc;
  logic        row_fire;
  assign row_fire = rd1_v && rd1_last;

  always_ff @(posedge clk) begin
    if (rd1_v) begin
      pxa <= pxb;
      pxb <= pxc;
      pxc <= rdata;
    end
  end

  logic                     row_v [3];
  logic signed [LINE_W-1:0] row_y [3];
  logic [RTAG_W-1:0]        row_tag [3];
  logic                     col_fire;
  logic signed [LINE_W-1:0] la [3], lb [3], lc [3];
  logic                     col_v [3];
  logic signed [OUT_W-1:0]  col_y [3];
  logic [CTAG_W-1:0]        col_tag [3];
  logic [7:0]               chan [3];

  assign col_fire = row_v[0] && row_tag[0][1:0] == 2'd3;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    bir_cubic #(.W(PIX_W), .TW(RTAG_W)) u_row (
      .clk     (clk),
      .rst     (rst),
      .in_v    (row_fire),
      .a       ($signed({1'b0, pxa[23-8*ch -: 8], {FRAC_W{1'b0}}})),
      .b       ($signed({1'b0, pxb[23-8*ch -: 8], {FRAC_W{1'b0}}})),
      .c       ($signed({1'b0, pxc[23-8*ch -: 8], {FRAC_W{1'b0}}})),
      .d       ($signed({1'b0, rdata[23-8*ch -: 8], {FRAC_W{1'b0}}})),
      .t       (rd1_xf),
      .tag_in  ({rd1_yf, rd1_dcol, rd1_drow, rd1_row}),
      .out_v   (row_v[ch]),
      .y       (row_y[ch]),
      .tag_out (row_tag[ch])
    );

    always_ff @(posedge clk) begin
      if (row_v[0]) begin
        la[ch] <= lb[ch];
        lb[ch] <= lc[ch];
        lc[ch] <= row_y[ch];
      end
    end

    bir_cubic #(.W(LINE_W), .TW(CTAG_W)) u_col (
      .clk     (clk),
      .rst     (rst),
      .in_v    (col_fire),
      .a       (la[ch]),
      .b       (lb[ch]),
      .c       (lc[ch]),
      .d       (row_y[ch]),
      .t       (row_tag[0][RTAG_W-1 -: FRAC_W]),
      .tag_in  (row_tag[0][CTAG_W+1:2]),
      .out_v   (col_v[ch]),
      .y       (col_y[ch]),
      .tag_out (col_tag[ch])
    );

    // clamp to the byte range then drop the fraction
    always_comb begin
      if (col_y[ch] < 0)         chan[ch] = 8'd0;
      else if (col_y[ch] > VMAX) chan[ch] = 8'd255;
      else                       chan[ch] = col_y[ch][FRAC_W+7:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= col_v[0];
  end

  always_ff @(posedge clk) begin
    out_red   <= chan[0];
    out_green <= chan[1];
    out_blue  <= chan[2];
    out_col   <= col_tag[0][23:12];
    out_row   <= col_tag[0][11:0];
  end

  `BIR_ASSERT(a_sample_busy, (start && !busy && action == ACT_SAMPLE) |=> busy)
  `BIR_ASSERT(a_read_count, (state == ST_READ && cnt != 4'hF) |=> (state == ST_READ && cnt == $past(cnt) + 4'd1))
  `BIR_ASSERT(a_out_spacing, out_valid |=> !out_valid)
  `BIR_ASSERT(a_col_after_row, col_fire |-> $past(rd1_v, 7))
  `BIR_ASSERT_RST(a_reset_quiet, rst |=> (!out_valid && !busy))

endmodule

// ===== hdl/bir_ram.sv =====
module bir_ram import bir_pkg::*; #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bir_cubic.sv =====
module bir_cubic import bir_pkg::*; #(
  parameter int W  = 25,
  parameter int TW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_v,
  input  logic signed [W-1:0]    a,
  input  logic signed [W-1:0]    b,
  input  logic signed [W-1:0]    c,
  input  logic signed [W-1:0]    d,
  input  logic [FRAC_W-1:0]      t,
  input  logic [TW-1:0]          tag_in,
  output logic                   out_v,
  output logic signed [W+5:0]    y,
  output logic [TW-1:0]          tag_out
);

  localparam int AW = W + 6;
  localparam int PW = AW + FRAC_W + 1;

  logic signed [AW-1:0] ae, be, ce, de;
  assign ae = {{6{a[W-1]}}, a};
  assign be = {{6{b[W-1]}}, b};
  assign ce = {{6{c[W-1]}}, c};
  assign de = {{6{d[W-1]}}, d};

  // stage regs: 1 coeffs, 2 mul, 3 add, 4 mul, 5 add, 6 mul, 7 add
  logic v1, v2, v3, v4, v5, v6, v7;
  logic [FRAC_W-1:0] t1, t2, t3, t4, t5;
  logic [TW-1:0] g1, g2, g3, g4, g5, g6, g7;
  logic signed [AW-1:0] a2, b2, c2, d2;
  logic signed [AW-1:0] b2_2, c2_2, d2_2, c2_3, d2_3, c2_4, d2_4, d2_5, d2_6;
  logic signed [AW-1:0] acc3, acc5, acc7;
  logic signed [PW-1:0] p2, p4, p6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v1 <= in_v; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    // doubled catmull-rom coefficients
    a2 <= de - ae + (be <<< 1) + be - (ce <<< 1) - ce;
    b2 <= (ae <<< 1) - (be <<< 2) - be + (ce <<< 2) - de;
    c2 <= ce - ae;
    d2 <= be <<< 1;
    t1 <= t;
    g1 <= tag_in;

    p2   <= a2 * $signed({1'b0, t1});
    b2_2 <= b2; c2_2 <= c2; d2_2 <= d2;
    t2 <= t1; g2 <= g1;

    acc3 <= p2[AW+FRAC_W-1:FRAC_W] + b2_2;
    c2_3 <= c2_2; d2_3 <= d2_2;
    t3 <= t2; g3 <= g2;

    p4   <= acc3 * $signed({1'b0, t3});
    c2_4 <= c2_3; d2_4 <= d2_3;
    t4 <= t3; g4 <= g3;

    acc5 <= p4[AW+FRAC_W-1:FRAC_W] + c2_4;
    d2_5 <= d2_4;
    t5 <= t4; g5 <= g4;

    p6   <= acc5 * $signed({1'b0, t5});
    d2_6 <= d2_5;
    g6 <= g5;

    acc7 <= p6[AW+FRAC_W-1:FRAC_W] + d2_6;
    g7 <= g6;
  end

  assign out_v   = v7;
  assign y       = {acc7[AW-1], acc7[AW-1:1]};
  assign tag_out = g7;

endmodule

// ===== verif/bicubic_resampler_checker.sv =====
module bicubic_resampler_checker import bir_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  action,
  input  logic [7:0]            load_col,
  input  logic [7:0]            load_row,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [11:0]           dest_col,
  input  logic [11:0]           dest_row,
  input  logic                  out_valid,
  input  logic [7:0]            out_red,
  input  logic [7:0]            out_green,
  input  logic [7:0]            out_blue,
  input  logic [11:0]           out_col,
  input  logic [11:0]           out_row,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] col;
    logic [11:0] row;
  } sample_px_t;

  logic [23:0]           pixels [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
  logic [SIZE_REG_W-1:0] img_w, img_h;
  logic [STEP_W-1:0]     step_x, step_y;
  sample_px_t            expected_px [$];

  assign pending = expected_px.size();

  function automatic longint cubic(longint a, longint b, longint c, longint d, longint t);
    longint ca, cb, cc, cd, acc;
    ca = -a + 3*b - 3*c + d;
    cb = 2*a - 5*b + 4*c - d;
    cc = c - a;
    cd = 2*b;
    acc = ca;
    acc = ((acc * t) >>> 16) + cb;
    acc = ((acc * t) >>> 16) + cc;
    acc = ((acc * t) >>> 16) + cd;
    return acc >>> 1;
  endfunction

  function automatic longint limit_size(logic [SIZE_REG_W-1:0] r, longint maxv);
    if (r == 0) return 1;
    if (longint'(r) > maxv) return maxv;
    return longint'(r);
  endfunction

  function automatic longint clip(longint v, longint size);
    if (v < 0) return 0;
    if (v > size - 1) return size - 1;
    return v;
  endfunction

  function automatic sample_px_t interpolate(logic [11:0] dc, logic [11:0] dr);
    sample_px_t res;
    longint w, h, px, py, xi, yi, xf, yf, v;
    longint cols [4];
    longint rows [4];
    longint s [4];
    longint line [4];
    logic [7:0] chan [3];
    w = limit_size(img_w, MAX_WIDTH_DEF);
    h = limit_size(img_h, MAX_HEIGHT_DEF);
    px = longint'(dc) * longint'(step_x) - 32768;
    py = longint'(dr) * longint'(step_y) - 32768;
    xi = px >>> 16;
    yi = py >>> 16;
    xf = px - xi * 65536;
    yf = py - yi * 65536;
    for (int k = 0; k < 4; k++) begin
      cols[k] = clip(xi - 1 + k, w);
      rows[k] = clip(yi - 1 + k, h);
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++)
          s[c] = longint'((pixels[rows[r]*MAX_WIDTH_DEF + cols[c]] >> (16 - 8*ch)) & 8'hff)
                 * 65536;
        line[r] = cubic(s[0], s[1], s[2], s[3], xf);
      end
      v = cubic(line[0], line[1], line[2], line[3], yf);
      if (v < 0) v = 0;
      if (v > 255 * 65536) v = 255 * 65536;
      chan[ch] = v[23:16];
    end
    res.red = chan[0];
    res.green = chan[1];
    res.blue = chan[2];
    res.col = dc;
    res.row = dr;
    return res;
  endfunction

  always @(posedge clk) begin
    sample_px_t want;
    if (rst) begin
      img_w <= SIZE_REG_W'(256);
      img_h <= SIZE_REG_W'(256);
      step_x <= STEP_W'(65536);
      step_y <= STEP_W'(65536);
      expected_px.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_WIDTH:  img_w <= cfg_data[SIZE_REG_W-1:0];
          REG_SRC_HEIGHT: img_h <= cfg_data[SIZE_REG_W-1:0];
          REG_STEP_H:     step_x <= cfg_data[STEP_W-1:0];
          REG_STEP_V:     step_y <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (action == ACT_LOAD)
          pixels[{load_row, load_col}] = {in_red, in_green, in_blue};
        else
          expected_px.push_back(interpolate(dest_col, dest_row));
      end
      if (out_valid) begin
        if (expected_px.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat col %0d row %0d", out_col, out_row);
        end else begin
          want = expected_px.pop_front();
          if (want.red !== out_red || want.green !== out_green || want.blue !== out_blue ||
              want.col !== out_col || want.row !== out_row) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected rgb %0d %0d %0d at %0d,%0d got %0d %0d %0d at %0d,%0d",
                       want.red, want.green, want.blue, want.col, want.row,
                       out_red, out_green, out_blue, out_col, out_row);
          end
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
module testbench import bir_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 0, rst = 1;
  logic start = 0, action = ACT_LOAD;
  logic [7:0] load_col = 0, load_row = 0, in_red = 0, in_green = 0, in_blue = 0;
  logic [11:0] dest_col = 0, dest_row = 0;
  logic cfg_valid = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  logic busy, out_valid, cfg_ready;
  logic [7:0] out_red, out_green, out_blue;
  logic [11:0] out_col, out_row;
  int pending, mismatches, cycles, items_sent, pause_pct;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  bicubic_image_resampler_unit u_top (.*);
  bicubic_resampler_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic pause_maybe();
    if (pause_pct > 0 && $urandom_range(99) < pause_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic issue_beat();
    start <= 1;
    do @(posedge clk); while (busy);
    items_sent++;
    pause_pct = items_sent < 300 ? 6 : items_sent < 600 ? 82 : 0;
  endtask

  task automatic load_px(int c, int r, logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
    pause_maybe();
    action <= ACT_LOAD;
    load_col <= 8'(c);
    load_row <= 8'(r);
    in_red <= rd;
    in_green <= gr;
    in_blue <= bl;
    dest_col <= 12'($urandom);
    dest_row <= 12'($urandom);
    issue_beat();
  endtask

  task automatic sample_px(logic [11:0] c, logic [11:0] r);
    pause_maybe();
    action <= ACT_SAMPLE;
    dest_col <= c;
    dest_row <= r;
    load_col <= 8'($urandom);
    load_row <= 8'($urandom);
    in_red <= 8'($urandom);
    in_green <= 8'($urandom);
    in_blue <= 8'($urandom);
    issue_beat();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // block must be idle before touching the registers
  task automatic wait_drained();
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // loads every pixel a clamped neighbourhood can reach, then samples with random loads mixed in
  task automatic run_setting(int w, int h, int sx, int sy, int n);
    int ew, eh;
    wait_drained();
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_STEP_H, CFG_DATA_W'(sx));
    write_reg(REG_STEP_V, CFG_DATA_W'(sy));
    ew = w == 0 ? 1 : w > 256 ? 256 : w;
    eh = h == 0 ? 1 : h > 256 ? 256 : h;
    for (int r = 0; r < eh; r++)
      for (int c = 0; c < ew; c++)
        load_px(c, r, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        load_px($urandom_range(255), $urandom_range(255), 8'($urandom), 8'($urandom),
                8'($urandom));
      else if ($urandom_range(1))
        sample_px(12'($urandom_range(31)), 12'($urandom_range(31)));
      else
        sample_px(12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    pause_pct = 6;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: 4x4 red/green checkerboard of extreme bytes, corner, edge and interior samples
    write_reg(REG_UNUSED, '1);
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(4));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(4));
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        load_px(c, r, ((r + c) % 2) ? 8'hff : 8'h00, ((r + c) % 2) ? 8'h00 : 8'hff,
                (c == 0) ? 8'hff : 8'h00);
    sample_px(0, 0);
    sample_px(12'hfff, 12'hfff);
    sample_px(1, 2);
    sample_px(3, 0);
    sample_px(12'hfff, 0);
    sample_px(0, 12'hfff);
    // beyond-image load still lands in the store
    load_px(200, 200, 8'hff, 8'hff, 8'hff);
    load_px(255, 255, 8'h00, 8'h80, 8'hff);
    run_setting(1, 1, 0, 25'h1ffffff, 40);
    run_setting(0, 3, 16777216, 12345, 40);
    run_setting(511, 1, $urandom, $urandom, 60);
    run_setting(1, 300, $urandom_range(131072), $urandom_range(16777216), 60);
    run_setting(5, 7, $urandom_range(131072), $urandom_range(131072), 60);
    run_setting(7, 5, $urandom_range(40000, 90000), $urandom_range(20000, 70000), 60);
    wait_drained();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// ===== bicubic_image_resampler_unit.f =====
+incdir+hdl
hdl/bir_pkg.sv
hdl/bir_ram.sv
hdl/bir_cubic.sv
hdl/bicubic_image_resampler_unit.sv
verif/bicubic_resampler_checker.sv
verif/testbench.sv
